[hdl/rps_pkg.sv]
// rps_pkg: shared types, constants and the xorshift32 step for the permutation shuffler
// used by rps_mod_unit and random_permutation_shuffler_core; no dependencies
package rps_pkg;

  localparam int unsigned SEED_W    = 32;
  localparam int unsigned IDX_W     = 8;
  localparam int unsigned DVS_W     = IDX_W + 1;
  localparam int unsigned TBL_DEPTH = 256;
  localparam int unsigned DIV_STEPS = SEED_W;
  localparam int unsigned DCNT_W    = $clog2(DIV_STEPS);

  localparam int unsigned XS_SHL_A = 13;
  localparam int unsigned XS_SHR_B = 17;
  localparam int unsigned XS_SHL_C = 5;

  typedef enum logic {
    CMD_SHUFFLE = 1'b0,
    CMD_READ    = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_DATA,
    ST_FILL,
    ST_ADV,
    ST_DIV,
    ST_WR_I,
    ST_WR_J,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              start;
    logic [SEED_W-1:0] dividend;
    logic [DVS_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] rem;
  } div_rsp_t;

  function automatic logic [SEED_W-1:0] xs_advance(logic [SEED_W-1:0] x);
    logic [SEED_W-1:0] y;
    y = x ^ (x << XS_SHL_A);
    y = y ^ (y >> XS_SHR_B);
    y = y ^ (y << XS_SHL_C);
    return y;
  endfunction

endpackage

[hdl/rps_mod_unit.sv]
// rps_mod_unit: restoring remainder unit, one dividend bit per cycle
// depends on rps_pkg (div_req_t, div_rsp_t, widths)
module rps_mod_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rps_pkg::div_req_t req_i,
  output rps_pkg::div_rsp_t rsp_o
);
  import rps_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic [SEED_W-1:0] dvd_q, dvd_d;
  logic [DVS_W-1:0]  dvs_q, dvs_d;
  logic [DVS_W-1:0]  rem_q, rem_d;
  logic [DVS_W:0]    trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[SEED_W-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the trial never overflows
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = DVS_W'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = trial[DVS_W-1:0];
      end
      dvd_d = {dvd_q[SEED_W-2:0], 1'b0};
      cnt_d = cnt_q + DCNT_W'(1);
      if (cnt_q == DCNT_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q[IDX_W-1:0];

endmodule

[hdl/random_permutation_shuffler_core.sv]
// random permutation shuffler: usage
// input channel (in_valid_i/in_ready_o) carries command_i, seed_i, index_i; output
// channel (out_valid_o/out_ready_i) carries entry_value_o and shuffle_done_o, one
// result per input transfer, in order.
// a read returns the table entry at index_i; its result is loaded into the output
// register once that register is free. a shuffle loads the identity order, then
// makes COUNT-1 swap steps: each advances the xorshift32 generator, waits for the
// bit-serial remainder unit and writes both swapped entries back through the single
// table write port. a shuffle answers with shuffle_done_o=1 and entry_value_o=0.
// one item is worked on at a time; in_ready_o is high only while no item is in
// work, and a finished result may still wait in the output register then.
// a stalled receiver holds the output register; a finished item waits until it
// can be loaded there.
// after reset the table reads as all zeros; entries at or beyond COUNT always
// read zero. the table itself has no reset and needs no clearing pass.
module random_permutation_shuffler_core #(
  parameter int unsigned COUNT = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       command_i,
  input  logic [rps_pkg::SEED_W-1:0] seed_i,
  input  logic [rps_pkg::IDX_W-1:0]  index_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [rps_pkg::IDX_W-1:0]  entry_value_o,
  output logic                       shuffle_done_o
);
  import rps_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(COUNT - 1);
  localparam logic [DVS_W-1:0] COUNT_DVS = DVS_W'(COUNT);

  state_e            state_q, state_d;
  logic [SEED_W-1:0] x_q, x_d;
  logic [IDX_W-1:0]  i_q, i_d;
  logic [IDX_W-1:0]  j_q, j_d;
  logic [IDX_W-1:0]  ti_q, ti_d;
  logic [IDX_W-1:0]  fill_q, fill_d;
  logic              shuffled_q, shuffled_d;
  logic              rd_zero_q, rd_zero_d;
  logic              out_valid_q, out_valid_d;
  logic [IDX_W-1:0]  entry_q, entry_d;
  logic              sdone_q, sdone_d;

  logic              in_xfer;
  logic              slot_free;
  logic [SEED_W-1:0] x_next;

  logic [IDX_W-1:0]  mem [TBL_DEPTH];
  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  mem_waddr, mem_wdata, mem_raddr;
  logic [IDX_W-1:0]  rdata_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  rps_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign x_next     = xs_advance(x_q);

  always_comb begin
    state_d          = state_q;
    x_d              = x_q;
    i_d              = i_q;
    j_d              = j_q;
    ti_d             = ti_q;
    fill_d           = fill_q;
    shuffled_d       = shuffled_q;
    rd_zero_d        = rd_zero_q;
    out_valid_d      = out_valid_q && !out_ready_i;
    entry_d          = entry_q;
    sdone_d          = sdone_q;
    mem_we           = 1'b0;
    mem_waddr        = i_q;
    mem_wdata        = rdata_q;
    mem_re           = 1'b0;
    mem_raddr        = i_q;
    div_req.start    = 1'b0;
    div_req.dividend = x_next;
    div_req.divisor  = {1'b0, i_q} + DVS_W'(1);

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (command_i == CMD_READ) begin
            mem_re    = 1'b1;
            mem_raddr = index_i;
            rd_zero_d = !shuffled_q || ({1'b0, index_i} >= COUNT_DVS);
            state_d   = ST_RD_DATA;
          end else begin
            x_d     = seed_i | SEED_W'(1);
            fill_d  = '0;
            state_d = ST_FILL;
          end
        end
      end
      ST_RD_DATA: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          entry_d     = rd_zero_q ? '0 : rdata_q;
          sdone_d     = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = fill_q;
        mem_wdata = fill_q;
        fill_d    = fill_q + IDX_W'(1);
        if (fill_q == LAST_IDX) begin
          i_d     = LAST_IDX;
          state_d = ST_ADV;
        end
      end
      ST_ADV: begin
        // entry i is fetched while the remainder is worked out
        x_d           = x_next;
        div_req.start = 1'b1;
        mem_re        = 1'b1;
        mem_raddr     = i_q;
        state_d       = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          j_d       = div_rsp.rem;
          ti_d      = rdata_q;
          mem_re    = 1'b1;
          mem_raddr = div_rsp.rem;
          state_d   = ST_WR_I;
        end
      end
      ST_WR_I: begin
        mem_we    = 1'b1;
        mem_waddr = i_q;
        mem_wdata = rdata_q;
        state_d   = ST_WR_J;
      end
      ST_WR_J: begin
        mem_we    = 1'b1;
        mem_waddr = j_q;
        mem_wdata = ti_q;
        if (i_q == IDX_W'(1)) begin
          state_d = ST_DONE;
        end else begin
          i_d     = i_q - IDX_W'(1);
          state_d = ST_ADV;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          shuffled_d  = 1'b1;
          out_valid_d = 1'b1;
          entry_d     = '0;
          sdone_d     = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      x_q         <= '0;
      shuffled_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      x_q         <= x_d;
      shuffled_q  <= shuffled_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q       <= i_d;
    j_q       <= j_d;
    ti_q      <= ti_d;
    fill_q    <= fill_d;
    rd_zero_q <= rd_zero_d;
    entry_q   <= entry_d;
    sdone_q   <= sdone_d;
  end

  // permutation table, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign entry_value_o  = entry_q;
  assign shuffle_done_o = sdone_q;

`ifndef NO_ASSERTIONS
  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV))
    else $error("remainder result outside the wait state");

  a_swap_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WR_J) |-> ((j_q <= i_q) && (i_q != '0)))
    else $error("swap partner out of range");

  a_shuffle_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && shuffle_done_o) |-> (entry_value_o == '0))
    else $error("shuffle result carries a nonzero entry");

  a_load_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && state_q != ST_IDLE) |=> $stable(entry_q))
    else $error("output register overwritten while stalled");
`endif

endmodule
